### hdl/rlrd_pkg.sv
// ----------------------------------------------------------------------------
// Raster drawer package
// Shared types, codes and constants of the raster line and rectangle drawer.
// ----------------------------------------------------------------------------
package rlrd_pkg;

  localparam int DEF_ROWS    = 20;
  localparam int DEF_COLS    = 36;
  localparam int COORD_W     = 6;
  localparam int CNT_W       = 7;
  localparam int QUEUE_DEPTH = 2;
  localparam int ANGLE_TURN  = 360;
  localparam int MOD_STEPS   = 7;

  localparam logic [2:0] SHADE_WHITE = 3'd4;
  localparam logic [2:0] SHADE_MAX   = 3'd4;

  typedef enum logic [1:0] {
    CMD_LINE  = 2'd0,
    CMD_RECT  = 2'd1,
    CMD_SHADE = 2'd2,
    CMD_READ  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    STATUS_DONE    = 2'd0,
    STATUS_IGNORED = 2'd1,
    STATUS_READ    = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    OP_IGNORE,
    OP_LINE,
    OP_RECT,
    OP_SHADE,
    OP_READ
  } op_kind_e;

  typedef enum logic [1:0] {
    F_IDLE,
    F_MOD,
    F_PUSH
  } front_state_e;

  typedef enum logic [2:0] {
    B_CLEAR,
    B_IDLE,
    B_LINE,
    B_RECT,
    B_READ,
    B_RDATA
  } back_state_e;

  typedef struct packed {
    logic              valid;
    logic signed [1:0] dr;
    logic signed [1:0] dc;
  } dir_t;

  typedef struct packed {
    op_kind_e             kind;
    logic [COORD_W-1:0]   row;
    logic [COORD_W-1:0]   col;
    logic signed [1:0]    dr;
    logic signed [1:0]    dc;
    logic [CNT_W-1:0]     count;
    logic [COORD_W-1:0]   row_hi;
    logic [COORD_W-1:0]   col_hi;
    logic signed [3:0]    step;
  } op_t;

  function automatic dir_t angle_dir(logic [8:0] rem);
    dir_t d;
    d.valid = 1'b1;
    case (rem)
      9'd0: begin
        d.dr = -2'sd1; d.dc = 2'sd0;
      end
      9'd45: begin
        d.dr = -2'sd1; d.dc = 2'sd1;
      end
      9'd90: begin
        d.dr = 2'sd0; d.dc = 2'sd1;
      end
      9'd135: begin
        d.dr = 2'sd1; d.dc = 2'sd1;
      end
      9'd180: begin
        d.dr = 2'sd1; d.dc = 2'sd0;
      end
      9'd225: begin
        d.dr = 2'sd1; d.dc = -2'sd1;
      end
      9'd270: begin
        d.dr = 2'sd0; d.dc = -2'sd1;
      end
      9'd315: begin
        d.dr = -2'sd1; d.dc = -2'sd1;
      end
      default: begin
        d.valid = 1'b0; d.dr = 2'sd0; d.dc = 2'sd0;
      end
    endcase
    return d;
  endfunction

endpackage

### hdl/rlrd_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rlrd_ram #(
  parameter int WIDTH = 3,
  parameter int DEPTH = 720,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/rlrd_front.sv
// ----------------------------------------------------------------------------
// Raster drawer command front end
// Accepts a command, reduces the angle modulo a full turn one step per cycle,
// checks the line geometry against the canvas and queues a decoded operation.
// ----------------------------------------------------------------------------
module rlrd_front #(
  parameter int CANVAS_ROWS = rlrd_pkg::DEF_ROWS,
  parameter int CANVAS_COLS = rlrd_pkg::DEF_COLS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               hold_i,
  output logic               busy_o,
  input  logic [1:0]         command_i,
  input  logic signed [7:0]  start_row_i,
  input  logic signed [7:0]  start_col_i,
  input  logic signed [7:0]  length_i,
  input  logic signed [15:0] angle_i,
  input  logic signed [3:0]  shade_step_i,
  input  logic               full_i,
  output logic               push_o,
  output rlrd_pkg::op_t      op_o
);

  import rlrd_pkg::*;

  localparam logic signed [9:0] ROWS_S = 10'(CANVAS_ROWS);
  localparam logic signed [9:0] COLS_S = 10'(CANVAS_COLS);

  front_state_e state_q, state_d;

  logic [1:0]         cmd_q;
  logic signed [7:0]  sr_q, sc_q, len_q;
  logic signed [3:0]  step_q;
  logic               neg_q;
  logic [15:0]        mag_q, mag_d;
  logic [2:0]         k_q, k_d;
  logic               accept;
  logic [15:0]        sub_val;

  logic [8:0]         rem;
  dir_t               dir;
  logic               ang_ok;
  logic [7:0]         len_mag;
  logic [CNT_W-1:0]   cnt;
  logic signed [1:0]  dr_f, dc_f;
  logic signed [9:0]  sr_s, sc_s, cnt_s, er_s, ec_s;
  logic signed [9:0]  rlo, rhi, clo, chi;
  logic               start_ok, end_ok, geom_ok;

  function automatic logic on_canvas(logic signed [9:0] r, logic signed [9:0] c);
    return (r >= 0) && (r < ROWS_S) && (c >= 0) && (c < COLS_S);
  endfunction

  assign busy_o  = (state_q != F_IDLE) || hold_i;
  assign accept  = start_i && !busy_o;
  assign sub_val = 16'(ANGLE_TURN) << k_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      F_IDLE: begin
        if (accept) begin
          state_d = F_MOD;
        end
      end
      F_MOD: begin
        if (k_q == 3'd0) begin
          state_d = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!full_i) begin
          state_d = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_comb begin
    mag_d = mag_q;
    k_d   = k_q;
    case (state_q)
      F_IDLE: begin
        mag_d = angle_i[15] ? 16'(-angle_i) : 16'(angle_i);
        k_d   = 3'(MOD_STEPS - 1);
      end
      F_MOD: begin
        if (mag_q >= sub_val) begin
          mag_d = mag_q - sub_val;
        end
        k_d = k_q - 3'd1;
      end
      default: begin
        mag_d = mag_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
    k_q   <= k_d;
    if (accept) begin
      cmd_q  <= command_i;
      sr_q   <= start_row_i;
      sc_q   <= start_col_i;
      len_q  <= length_i;
      step_q <= shade_step_i;
      neg_q  <= angle_i[15];
    end
  end

  always_comb begin
    rem     = mag_q[8:0];
    dir     = angle_dir(rem);
    ang_ok  = dir.valid && (!neg_q || (rem == 9'd0));
    len_mag = len_q[7] ? 8'(-len_q) : 8'(len_q);
    cnt     = CNT_W'(len_mag - 8'd1);
    dr_f    = len_q[7] ? -dir.dr : dir.dr;
    dc_f    = len_q[7] ? -dir.dc : dir.dc;
    sr_s    = 10'(sr_q);
    sc_s    = 10'(sc_q);
    cnt_s   = {3'b000, cnt};
    er_s    = (dr_f > 0) ? sr_s + cnt_s : (dr_f < 0) ? sr_s - cnt_s : sr_s;
    ec_s    = (dc_f > 0) ? sc_s + cnt_s : (dc_f < 0) ? sc_s - cnt_s : sc_s;
    rlo     = (sr_s < er_s) ? sr_s : er_s;
    rhi     = (sr_s < er_s) ? er_s : sr_s;
    clo     = (sc_s < ec_s) ? sc_s : ec_s;
    chi     = (sc_s < ec_s) ? ec_s : sc_s;
    start_ok = on_canvas(sr_s, sc_s);
    end_ok   = on_canvas(er_s, ec_s);
    geom_ok  = (len_q != 8'sd0) && ang_ok && start_ok && end_ok;

    op_o.row    = sr_s[COORD_W-1:0];
    op_o.col    = sc_s[COORD_W-1:0];
    op_o.dr     = dr_f;
    op_o.dc     = dc_f;
    op_o.count  = cnt;
    op_o.row_hi = rhi[COORD_W-1:0];
    op_o.col_hi = chi[COORD_W-1:0];
    op_o.step   = step_q;
    op_o.kind   = OP_IGNORE;
    case (cmd_e'(cmd_q))
      CMD_LINE: begin
        op_o.kind = geom_ok ? OP_LINE : OP_IGNORE;
      end
      CMD_RECT: begin
        op_o.kind = geom_ok ? OP_RECT : OP_IGNORE;
        op_o.row  = rlo[COORD_W-1:0];
        op_o.col  = clo[COORD_W-1:0];
      end
      CMD_SHADE: begin
        op_o.kind = OP_SHADE;
      end
      CMD_READ: begin
        op_o.kind = start_ok ? OP_READ : OP_IGNORE;
      end
      default: begin
        op_o.kind = OP_IGNORE;
      end
    endcase
  end

  assign push_o = (state_q == F_PUSH) && !full_i;

endmodule

### hdl/rlrd_fifo.sv
// ----------------------------------------------------------------------------
// Raster drawer operation queue
// Short first-in first-out queue of decoded operations between front and back.
// ----------------------------------------------------------------------------
module rlrd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  rlrd_pkg::op_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output rlrd_pkg::op_t data_o,
  output logic          empty_o
);

  import rlrd_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

  op_t               slots_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [CNT_QW-1:0] fill_q, fill_d;

  assign full_o  = (fill_q == CNT_QW'(QUEUE_DEPTH));
  assign empty_o = (fill_q == '0);
  assign data_o  = slots_q[rd_q];

  always_comb begin
    wr_d   = wr_q;
    rd_d   = rd_q;
    fill_d = fill_q;
    if (push_i) begin
      wr_d = (wr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
    end
    if (push_i && !pop_i) begin
      fill_d = fill_q + CNT_QW'(1);
    end else if (pop_i && !push_i) begin
      fill_d = fill_q - CNT_QW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= '0;
      rd_q   <= '0;
      fill_q <= '0;
    end else begin
      wr_q   <= wr_d;
      rd_q   <= rd_d;
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_q] <= data_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i) else $error("Operation pushed into a full queue.");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> !pop_i) else $error("Operation popped from an empty queue.");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CNT_QW'(QUEUE_DEPTH)) else $error("Queue fill count out of range.");

endmodule

### hdl/rlrd_back.sv
// ----------------------------------------------------------------------------
// Raster drawer back end
// Clears the canvas after reset, then executes queued operations one pixel
// per cycle and issues one result word for each.
// ----------------------------------------------------------------------------
module rlrd_back #(
  parameter int CANVAS_ROWS = rlrd_pkg::DEF_ROWS,
  parameter int CANVAS_COLS = rlrd_pkg::DEF_COLS
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          empty_i,
  input  rlrd_pkg::op_t op_i,
  output logic          pop_o,
  output logic          clearing_o,
  output logic          done_o,
  output logic [1:0]    status_o,
  output logic [2:0]    pixel_shade_o
);

  import rlrd_pkg::*;

  localparam int DEPTH = CANVAS_ROWS * CANVAS_COLS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  back_state_e state_q, state_d;

  logic [AW-1:0]      clr_q, clr_d;
  logic [COORD_W-1:0] row_q, row_d, col_q, col_d;
  logic [COORD_W-1:0] clo_q, clo_d, rhi_q, rhi_d, chi_q, chi_d;
  logic signed [1:0]  dr_q, dr_d, dc_q, dc_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [2:0]         shade_q, shade_d;
  logic               done_q, done_d;
  logic [1:0]         status_q, status_d;
  logic [2:0]         pix_q, pix_d;

  logic               we;
  logic [AW-1:0]      waddr, pix_addr;
  logic [2:0]         wdata, rdata;
  logic signed [4:0]  new_shade;
  logic               clr_last, rect_last;

  assign pix_addr  = AW'(int'(row_q) * CANVAS_COLS + int'(col_q));
  assign clr_last  = (clr_q == AW'(DEPTH - 1));
  assign rect_last = (col_q == chi_q) && (row_q == rhi_q);
  assign new_shade = $signed({2'b00, shade_q}) + 5'(op_i.step);

  assign pop_o      = (state_q == B_IDLE) && !empty_i;
  assign clearing_o = (state_q == B_CLEAR);

  always_comb begin
    state_d = state_q;
    case (state_q)
      B_CLEAR: begin
        if (clr_last) begin
          state_d = B_IDLE;
        end
      end
      B_IDLE: begin
        if (!empty_i) begin
          case (op_i.kind)
            OP_LINE: state_d = B_LINE;
            OP_RECT: state_d = B_RECT;
            OP_READ: state_d = B_READ;
            default: state_d = B_IDLE;
          endcase
        end
      end
      B_LINE: begin
        if (cnt_q == '0) begin
          state_d = B_IDLE;
        end
      end
      B_RECT: begin
        if (rect_last) begin
          state_d = B_IDLE;
        end
      end
      B_READ:  state_d = B_RDATA;
      B_RDATA: state_d = B_IDLE;
      default: state_d = B_IDLE;
    endcase
  end

  always_comb begin
    clr_d    = clr_q;
    row_d    = row_q;
    col_d    = col_q;
    clo_d    = clo_q;
    rhi_d    = rhi_q;
    chi_d    = chi_q;
    dr_d     = dr_q;
    dc_d     = dc_q;
    cnt_d    = cnt_q;
    shade_d  = shade_q;
    done_d   = 1'b0;
    status_d = status_q;
    pix_d    = pix_q;
    we       = 1'b0;
    waddr    = pix_addr;
    wdata    = shade_q;
    case (state_q)
      B_CLEAR: begin
        we    = 1'b1;
        waddr = clr_q;
        wdata = SHADE_WHITE;
        clr_d = clr_q + AW'(1);
      end
      B_IDLE: begin
        if (!empty_i) begin
          row_d = op_i.row;
          col_d = op_i.col;
          clo_d = op_i.col;
          rhi_d = op_i.row_hi;
          chi_d = op_i.col_hi;
          dr_d  = op_i.dr;
          dc_d  = op_i.dc;
          cnt_d = op_i.count;
          case (op_i.kind)
            OP_SHADE: begin
              done_d = 1'b1;
              pix_d  = '0;
              if (new_shade >= 0 && new_shade <= $signed({2'b00, SHADE_MAX})) begin
                shade_d  = new_shade[2:0];
                status_d = STATUS_DONE;
              end else begin
                status_d = STATUS_IGNORED;
              end
            end
            OP_IGNORE: begin
              done_d   = 1'b1;
              pix_d    = '0;
              status_d = STATUS_IGNORED;
            end
            default: begin
              done_d = 1'b0;
            end
          endcase
        end
      end
      B_LINE: begin
        we    = 1'b1;
        row_d = row_q + COORD_W'(dr_q);
        col_d = col_q + COORD_W'(dc_q);
        cnt_d = cnt_q - CNT_W'(1);
        if (cnt_q == '0) begin
          done_d   = 1'b1;
          status_d = STATUS_DONE;
          pix_d    = '0;
        end
      end
      B_RECT: begin
        we = 1'b1;
        if (col_q == chi_q) begin
          col_d = clo_q;
          row_d = row_q + COORD_W'(1);
        end else begin
          col_d = col_q + COORD_W'(1);
        end
        if (rect_last) begin
          done_d   = 1'b1;
          status_d = STATUS_DONE;
          pix_d    = '0;
        end
      end
      B_RDATA: begin
        done_d   = 1'b1;
        status_d = STATUS_READ;
        pix_d    = rdata;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= B_CLEAR;
      clr_q    <= '0;
      shade_q  <= '0;
      done_q   <= 1'b0;
      status_q <= STATUS_DONE;
      pix_q    <= '0;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      shade_q  <= shade_d;
      done_q   <= done_d;
      status_q <= status_d;
      pix_q    <= pix_d;
    end
  end

  always_ff @(posedge clk_i) begin
    row_q <= row_d;
    col_q <= col_d;
    clo_q <= clo_d;
    rhi_q <= rhi_d;
    chi_q <= chi_d;
    dr_q  <= dr_d;
    dc_q  <= dc_d;
    cnt_q <= cnt_d;
  end

  rlrd_ram #(
    .WIDTH(3),
    .DEPTH(DEPTH)
  ) u_canvas (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(pix_addr),
    .rdata_o(rdata)
  );

  assign done_o        = done_q;
  assign status_o      = status_q;
  assign pixel_shade_o = pix_q;

  a_shade_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    shade_q <= SHADE_MAX) else $error("Current shade left its range.");

  a_pixel_only_on_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && status_q != STATUS_READ) |-> pix_q == '0)
    else $error("Pixel shade reported without a read.");

  a_no_pop_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_CLEAR) |-> !pop_o) else $error("Operation taken during clear.");

  a_read_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_READ) |=> done_d && status_d == STATUS_READ)
    else $error("Read did not produce its result.");

endmodule

### hdl/raster_line_rect_drawer_unit.sv
// ----------------------------------------------------------------------------
// Raster line and rectangle drawer
// Canvas of shade values with line, rectangle fill, shade and read commands.
// ----------------------------------------------------------------------------
// After reset the canvas is cleared to white with busy_o high. A command is
// taken when start_i is high and busy_o is low; the front end then runs
// seven angle reduction steps and a decode and queue step, which waits
// while the queue is full, before it can take the next one. The back end
// writes one pixel per cycle through the single canvas write port: a line
// writes its pixels in order, a rectangle fill every pixel of the box (up
// to CANVAS_ROWS*CANVAS_COLS), a read passes through a request and a data
// state, and a shade change or ignored command is answered from idle.
// Every command gives exactly one result word, shown for one cycle with
// done_o high; the receiver cannot stall it.
module raster_line_rect_drawer_unit #(
  parameter int CANVAS_ROWS = rlrd_pkg::DEF_ROWS,
  parameter int CANVAS_COLS = rlrd_pkg::DEF_COLS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [1:0]         command_i,
  input  logic signed [7:0]  start_row_i,
  input  logic signed [7:0]  start_col_i,
  input  logic signed [7:0]  length_i,
  input  logic signed [15:0] angle_i,
  input  logic signed [3:0]  shade_step_i,
  output logic               done_o,
  output logic [1:0]         status_o,
  output logic [2:0]         pixel_shade_o
);

  import rlrd_pkg::*;

  op_t  push_op, head_op;
  logic push, pop, full, empty, clearing;

  rlrd_front #(
    .CANVAS_ROWS(CANVAS_ROWS),
    .CANVAS_COLS(CANVAS_COLS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .hold_i      (clearing),
    .busy_o      (busy_o),
    .command_i   (command_i),
    .start_row_i (start_row_i),
    .start_col_i (start_col_i),
    .length_i    (length_i),
    .angle_i     (angle_i),
    .shade_step_i(shade_step_i),
    .full_i      (full),
    .push_o      (push),
    .op_o        (push_op)
  );

  rlrd_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (push_op),
    .full_o (full),
    .pop_i  (pop),
    .data_o (head_op),
    .empty_o(empty)
  );

  rlrd_back #(
    .CANVAS_ROWS(CANVAS_ROWS),
    .CANVAS_COLS(CANVAS_COLS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .empty_i      (empty),
    .op_i         (head_op),
    .pop_o        (pop),
    .clearing_o   (clearing),
    .done_o       (done_o),
    .status_o     (status_o),
    .pixel_shade_o(pixel_shade_o)
  );

endmodule

### tb/rlrd_result_checker.sv
// ----------------------------------------------------------------------------
// Raster drawer result checker
// Watches the command and result channels of the raster line and rectangle
// drawer. It keeps its own canvas and shade, works out the result word of
// every accepted command and compares each result word, field by field,
// with the oldest one still expected.
// ----------------------------------------------------------------------------
module rlrd_result_checker #(
  parameter int CANVAS_ROWS = rlrd_pkg::DEF_ROWS,
  parameter int CANVAS_COLS = rlrd_pkg::DEF_COLS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               busy_i,
  input  logic [1:0]         command_i,
  input  logic signed [7:0]  start_row_i,
  input  logic signed [7:0]  start_col_i,
  input  logic signed [7:0]  length_i,
  input  logic signed [15:0] angle_i,
  input  logic signed [3:0]  shade_step_i,
  input  logic               done_i,
  input  logic [1:0]         status_i,
  input  logic [2:0]         pixel_shade_i,
  output int                 error_count_o,
  output int                 pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import rlrd_pkg::*;

  typedef struct packed {
    status_e    status;
    logic [2:0] shade;
  } result_word_t;

  logic [2:0]   canvas_q [CANVAS_ROWS*CANVAS_COLS];
  logic [2:0]   pen_shade_q;
  result_word_t expected_words_q [$];

  function automatic bit inside_canvas(int row, int col);
    return row >= 0 && row < CANVAS_ROWS && col >= 0 && col < CANVAS_COLS;
  endfunction

  function automatic result_word_t predict_drawing(cmd_e cmd, int row, int col, int len,
                                                   int ang, int step);
    result_word_t w;
    int dr;
    int dc;
    int end_row;
    int end_col;
    int next_shade;
    bit dir_ok;
    w.status = STATUS_IGNORED;
    w.shade  = 3'd0;
    dir_ok   = 1'b1;
    dr       = 0;
    dc       = 0;
    case (ang % ANGLE_TURN)
      0: begin
        dr = -1; dc = 0;
      end
      45: begin
        dr = -1; dc = 1;
      end
      90: begin
        dr = 0; dc = 1;
      end
      135: begin
        dr = 1; dc = 1;
      end
      180: begin
        dr = 1; dc = 0;
      end
      225: begin
        dr = 1; dc = -1;
      end
      270: begin
        dr = 0; dc = -1;
      end
      315: begin
        dr = -1; dc = -1;
      end
      default: begin
        dir_ok = 1'b0;
      end
    endcase
    case (cmd)
      CMD_LINE, CMD_RECT: begin
        if (len != 0 && dir_ok) begin
          if (len < 0) begin
            len = -len;
            dr  = -dr;
            dc  = -dc;
          end
          end_row = row + (len - 1) * dr;
          end_col = col + (len - 1) * dc;
          if (inside_canvas(row, col) && inside_canvas(end_row, end_col)) begin
            if (cmd == CMD_LINE) begin
              for (int i = 0; i < len; i++) begin
                canvas_q[(row + i * dr) * CANVAS_COLS + col + i * dc] = pen_shade_q;
              end
            end else begin
              for (int r = (row < end_row ? row : end_row);
                   r <= (row < end_row ? end_row : row); r++) begin
                for (int c = (col < end_col ? col : end_col);
                     c <= (col < end_col ? end_col : col); c++) begin
                  canvas_q[r * CANVAS_COLS + c] = pen_shade_q;
                end
              end
            end
            w.status = STATUS_DONE;
          end
        end
      end
      CMD_SHADE: begin
        next_shade = int'(pen_shade_q) + step;
        if (next_shade >= 0 && next_shade <= int'(SHADE_MAX)) begin
          pen_shade_q = next_shade[2:0];
          w.status    = STATUS_DONE;
        end
      end
      default: begin
        if (inside_canvas(row, col)) begin
          w.shade  = canvas_q[row * CANVAS_COLS + col];
          w.status = STATUS_READ;
        end
      end
    endcase
    return w;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch_p
    result_word_t want;
    if (!rst_ni) begin
      foreach (canvas_q[i]) canvas_q[i] = SHADE_WHITE;
      pen_shade_q = 3'd0;
      expected_words_q.delete();
      error_count_o <= 0;
      pending_o     <= 0;
    end else begin
      if (start_i && !busy_i) begin
        expected_words_q.push_back(predict_drawing(cmd_e'(command_i), start_row_i,
                                                   start_col_i, length_i, angle_i,
                                                   shade_step_i));
      end
      if (done_i) begin
        if (expected_words_q.size() == 0) begin
          $display("%0t: result word with nothing expected, status %0d shade %0d",
                   $time, status_i, pixel_shade_i);
          error_count_o <= error_count_o + 1;
        end else begin
          want = expected_words_q.pop_front();
          if (status_i !== want.status || pixel_shade_i !== want.shade) begin
            if (status_i !== want.status) begin
              $display("%0t: status mismatch, expected %0d, actual %0d",
                       $time, want.status, status_i);
            end
            if (pixel_shade_i !== want.shade) begin
              $display("%0t: pixel shade mismatch, expected %0d, actual %0d",
                       $time, want.shade, pixel_shade_i);
            end
            error_count_o <= error_count_o + 1;
          end
        end
      end
      pending_o <= expected_words_q.size();
    end
  end

endmodule

### tb/tb_raster_line_rect_drawer_unit.sv
// ----------------------------------------------------------------------------
// Raster drawer testbench
// Drives directed and random command words into the raster line and
// rectangle drawer under several sender idling phases, lets the checker
// predict and compare every result word, and prints the verdict.
// ----------------------------------------------------------------------------
module tb_raster_line_rect_drawer_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import rlrd_pkg::*;

  localparam int ROWS           = DEF_ROWS;
  localparam int COLS           = DEF_COLS;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int TAIL_CYCLES    = 40;
  localparam int PHASE_WORDS    = 200;

  logic               clk_i        = 1'b0;
  logic               rst_ni       = 1'b0;
  logic               start_i      = 1'b0;
  logic               busy_o;
  logic [1:0]         command_i    = CMD_READ;
  logic signed [7:0]  start_row_i  = '0;
  logic signed [7:0]  start_col_i  = '0;
  logic signed [7:0]  length_i     = '0;
  logic signed [15:0] angle_i      = '0;
  logic signed [3:0]  shade_step_i = '0;
  logic               done_o;
  logic [1:0]         status_o;
  logic [2:0]         pixel_shade_o;

  int error_count;
  int pending_words;
  int idle_pct;
  int stall_cycles = 0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  raster_line_rect_drawer_unit #(
    .CANVAS_ROWS(ROWS),
    .CANVAS_COLS(COLS)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .command_i    (command_i),
    .start_row_i  (start_row_i),
    .start_col_i  (start_col_i),
    .length_i     (length_i),
    .angle_i      (angle_i),
    .shade_step_i (shade_step_i),
    .done_o       (done_o),
    .status_o     (status_o),
    .pixel_shade_o(pixel_shade_o)
  );

  rlrd_result_checker #(
    .CANVAS_ROWS(ROWS),
    .CANVAS_COLS(COLS)
  ) checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_i       (busy_o),
    .command_i    (command_i),
    .start_row_i  (start_row_i),
    .start_col_i  (start_col_i),
    .length_i     (length_i),
    .angle_i      (angle_i),
    .shade_step_i (shade_step_i),
    .done_i       (done_o),
    .status_i     (status_o),
    .pixel_shade_i(pixel_shade_o),
    .error_count_o(error_count),
    .pending_o    (pending_words)
  );

  // Nothing accepted on either channel for too long means the block hung.
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic issue_command(input cmd_e cmd, input int row, input int col, input int len,
                               input int ang, input int step);
    int gap;
    gap = ($urandom_range(99, 0) < idle_pct) ? $urandom_range(6, 1) : 0;
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    command_i    <= cmd;
    start_row_i  <= row[7:0];
    start_col_i  <= col[7:0];
    length_i     <= len[7:0];
    angle_i      <= ang[15:0];
    shade_step_i <= step[3:0];
    start_i      <= 1'b1;
    do @(posedge clk_i); while (busy_o);
  endtask

  task automatic drain_results();
    start_i <= 1'b0;
    @(negedge clk_i);
    while (pending_words != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  initial begin : stimulus_p
    int phase_idle [4];
    int pick;
    int len;
    int ang;
    cmd_e cmd;
    phase_idle   = '{0, 49, 0, 21};
    idle_pct     = 21;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    issue_command(CMD_READ, 0, 0, 0, 0, 0);
    issue_command(CMD_READ, -1, 5, 0, 0, 0);
    issue_command(CMD_READ, ROWS, 0, 0, 0, 0);
    issue_command(CMD_READ, 0, COLS, 0, 0, 0);
    issue_command(CMD_READ, 127, -128, -1, -1, -1);
    issue_command(CMD_LINE, 0, 0, 0, 90, 0);
    issue_command(CMD_LINE, 5, 5, 3, -90, 0);
    issue_command(CMD_LINE, 5, 5, 3, 30, 0);
    issue_command(CMD_LINE, 0, COLS - 6, 7, 90, 0);
    issue_command(CMD_LINE, 0, COLS - 6, 6, 450, 0);
    issue_command(CMD_LINE, -1, 3, 3, 180, 0);
    issue_command(CMD_LINE, ROWS - 1, 0, -128, 32760, 0);
    issue_command(CMD_LINE, 10, 10, -4, 315, 0);
    issue_command(CMD_LINE, 2, 2, 127, 32767, 0);
    issue_command(CMD_LINE, 2, 2, 2, -32768, 0);
    issue_command(CMD_SHADE, 0, 0, 0, 0, 5);
    issue_command(CMD_SHADE, 0, 0, 0, 0, 3);
    issue_command(CMD_SHADE, 0, 0, 0, 0, -8);
    issue_command(CMD_SHADE, 0, 0, 0, 0, -4);
    issue_command(CMD_RECT, 0, 0, ROWS, 135, 0);
    issue_command(CMD_RECT, ROWS - 1, COLS - 1, ROWS, 315, 7);
    issue_command(CMD_RECT, 5, 5, -3, 90, 0);
    issue_command(CMD_READ, 10, 10, 0, 0, 0);
    issue_command(CMD_READ, 0, COLS - 1, 0, 0, 0);
    issue_command(CMD_READ, ROWS - 1, COLS - 1, 0, 0, 0);
    drain_results();

    for (int phase = 0; phase < 4; phase++) begin
      idle_pct = phase_idle[phase];
      for (int n = 0; n < PHASE_WORDS; n++) begin
        if ($urandom_range(99, 0) < 12) begin
          issue_command(cmd_e'($urandom_range(3, 0)), $urandom, $urandom, $urandom,
                        $urandom, $urandom);
        end else begin
          pick = $urandom_range(99, 0);
          cmd  = pick < 35 ? CMD_READ : pick < 60 ? CMD_LINE : pick < 80 ? CMD_RECT : CMD_SHADE;
          len  = ($urandom_range(19, 0) == 0) ? $urandom_range(ROWS, 1) : $urandom_range(6, 1);
          if ($urandom_range(1, 0) == 1) len = -len;
          if ($urandom_range(29, 0) == 0) len = 0;
          ang = $urandom_range(7, 0) * 45;
          if ($urandom_range(3, 0) == 0) ang = ang + ANGLE_TURN * $urandom_range(90, 0);
          if ($urandom_range(9, 0) == 0) ang = -ang;
          if ($urandom_range(14, 0) == 0) ang = ang + $urandom_range(44, 1);
          if ($urandom_range(6, 0) == 0) begin
            issue_command(cmd, int'($urandom_range(ROWS + 3, 0)) - 2,
                          int'($urandom_range(COLS + 3, 0)) - 2, len, ang,
                          int'($urandom_range(6, 0)) - 3);
          end else begin
            issue_command(cmd, $urandom_range(ROWS - 1, 0), $urandom_range(COLS - 1, 0),
                          len, ang, int'($urandom_range(6, 0)) - 3);
          end
        end
      end
      drain_results();
    end

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (error_count == 0 && pending_words == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
